[hw/rtl/stereo_linear_speed_resampler_macros.svh]
// Assertion macros for the stereo linear speed resampler.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef STEREO_LINEAR_SPEED_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_SPEED_RESAMPLER_MACROS_SVH

// Concurrent check clocked on clk_i, off while reset is asserted.
`define SLSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication check: antecedent implies consequent in the same cycle.
`define SLSR_ASSERT_IMP(label, ante, cons, msg) \
  `SLSR_ASSERT(label, (ante) |-> (cons), msg)

// Implication check: antecedent implies consequent in the next cycle.
`define SLSR_ASSERT_NEXT(label, ante, cons, msg) \
  `SLSR_ASSERT(label, (ante) |=> (cons), msg)

`endif

[hw/rtl/slsr_pkg.sv]
// Shared types and constants of the stereo linear speed resampler.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package slsr_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned FracBitsDef   = 12;
  localparam int unsigned SpeedBits     = 16;
  localparam int unsigned MaxResults    = 64;
  localparam int unsigned CntBits       = $clog2(MaxResults);
  // Minimum speed is one sixty-fourth of an input frame.
  localparam int unsigned MinSpeedShift = 6;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Controls from the phase sequencer to the lanes and the output stage.
  typedef struct packed {
    logic load;   // input transaction taken, update the held frame
    logic issue;  // start one interpolation in every lane
    logic last;   // issued result is the final one of this input
  } slsr_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/slsr_lane.sv]
// One channel lane: holds the previous sample and the frame difference,
// and interpolates at the phase from the sequencer. Depends on slsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slsr_lane
  import slsr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          issue_i,
  input  wire logic        [FRAC_BITS-1:0]   phase_i,
  output logic      signed [SAMPLE_BITS-2:0] half_o
);

  localparam int unsigned DiffW = SAMPLE_BITS + 1;
  localparam int unsigned ProdW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int unsigned SumW  = SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [SAMPLE_BITS-1:0] from_q;
  logic signed [DiffW-1:0]       diff_q, diff_d;
  logic signed [SAMPLE_BITS-1:0] base_q;
  logic signed [ProdW-1:0]       prod_q, prod_d;
  logic signed [SumW-1:0]        sum;

  assign diff_d = {sample_i[SAMPLE_BITS-1], sample_i} - {prev_q[SAMPLE_BITS-1], prev_q};
  assign prod_d = diff_q * $signed({1'b0, phase_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load_i) begin
      prev_q <= sample_i;
    end
  end

  // Difference and product stage carry no reset. The interpolation starts
  // from the frame held before the load, so keep it beside the difference.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= diff_d;
      from_q <= prev_q;
    end
    if (issue_i) begin
      base_q <= from_q;
      prod_q <= prod_d;
    end
  end

  // Floor of the scaled product, then halve; the sum stays in sample range.
  assign sum    = {{2{base_q[SAMPLE_BITS-1]}}, base_q} + prod_q[ProdW-1:FRAC_BITS];
  assign half_o = sum[SAMPLE_BITS-1:1];

endmodule

`default_nettype wire

[hw/rtl/slsr_seq.sv]
// Phase sequencer: walks the read phase across one input frame and
// issues one interpolation per cycle while the output stage advances. Depends on slsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slsr_seq
  import slsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 adv_i,
  input  wire logic [SpeedBits-1:0] speed_i,
  output slsr_ctl_t                 ctl_o,
  output logic      [FRAC_BITS-1:0] phase_o
);

  localparam int unsigned PhaseW = ((FRAC_BITS > SpeedBits) ? FRAC_BITS : SpeedBits) + 1;
  localparam logic [PhaseW-1:0]    PhaseOne = PhaseW'(1) << FRAC_BITS;
  localparam logic [SpeedBits-1:0] MinSpeed = SpeedBits'(1) << (FRAC_BITS - MinSpeedShift);
  localparam logic [CntBits-1:0]   CntLast  = CntBits'(MaxResults - 1);

  state_e               state_q, state_d;
  logic [PhaseW-1:0]    phase_q, phase_d, phase_next;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 primed_q, primed_d;
  logic [SpeedBits-1:0] sp;
  logic                 accept, ph_low, last;

  assign sp         = (speed_i < MinSpeed) ? MinSpeed : speed_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ph_low     = phase_q < PhaseOne;
  assign phase_next = phase_q + PhaseW'(sp);
  assign last       = (phase_next >= PhaseOne) || (cnt_q == CntLast);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && primed_q && ph_low) state_d = ST_RUN;
      ST_RUN:  if (ctl_o.issue && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    ctl_o.load  = accept;
    ctl_o.issue = (state_q == ST_RUN) && adv_i;
    ctl_o.last  = last;
  end

  assign phase_o = phase_q[FRAC_BITS-1:0];

  // Phase, result count and priming flag
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    primed_d = primed_q;
    if (accept) begin
      primed_d = 1'b1;
      cnt_d    = '0;
      if (primed_q && !ph_low) phase_d = phase_q - PhaseOne;
    end else if (ctl_o.issue) begin
      cnt_d = cnt_q + CntBits'(1);
      if (!last) begin
        phase_d = phase_next;
      end else if (phase_next >= PhaseOne) begin
        phase_d = phase_next - PhaseOne;
      end else begin
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= '0;
      cnt_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      primed_q <= primed_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stereo_linear_speed_resampler.sv]
// Stereo linear speed resampler: top level with speed register, phase sequencer,
// two lanes and output register. Depends on slsr_pkg, slsr_lane, slsr_seq and the macros header.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) takes one stereo frame per
//   transaction. Output channel (out_valid_o/out_ready_i) delivers
//   interpolated, halved stereo frames; last_o marks the final one of an input.
// - cfg_we_i writes cfg_wdata_i into the speed register (Q4.12 frames
//   per output); write only while the block is idle. Speeds below 1/64
//   are used as 1/64.
// - The first frame after reset is only stored. Each later frame is taken,
//   then gives one result per phase step left below one frame, at most 64;
//   the phase sequencer issues one step per cycle while the output advances.
// - Each result passes the product register, then the output register.
// - A stalled receiver freezes the product stage and the sequencer; nothing
//   is dropped. A new frame can be taken while the last results still wait.
// - Reset clears the phase, the held frame, the priming flag, all valid
//   flags and sets speed to one frame per output.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_linear_speed_resampler_macros.svh"

module stereo_linear_speed_resampler
  import slsr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic        [SpeedBits-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      signed [SAMPLE_BITS-2:0] left_out_o,
  output logic      signed [SAMPLE_BITS-2:0] right_out_o,
  output logic                               last_o
);

  localparam logic [SpeedBits-1:0] SpeedReset = SpeedBits'(1) << FRAC_BITS;

  logic [SpeedBits-1:0]          speed_q;
  slsr_ctl_t                     ctl;
  logic [FRAC_BITS-1:0]          phase;
  logic                          adv;
  logic                          s1_v_q, s1_last_q;
  logic                          out_v_q, out_last_q;
  logic signed [SAMPLE_BITS-2:0] left_half, right_half;
  logic signed [SAMPLE_BITS-2:0] left_q, right_q;

  // Advance the pipeline whenever the output register is free or drains.
  assign adv = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SpeedReset;
    end else if (cfg_we_i) begin
      speed_q <= cfg_wdata_i;
    end
  end

  slsr_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .adv_i     (adv),
    .speed_i   (speed_q),
    .ctl_o     (ctl),
    .phase_o   (phase)
  );

  slsr_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctl.load),
    .sample_i(left_sample_i),
    .issue_i (ctl.issue),
    .phase_i (phase),
    .half_o  (left_half)
  );

  slsr_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctl.load),
    .sample_i(right_sample_i),
    .issue_i (ctl.issue),
    .phase_i (phase),
    .half_o  (right_half)
  );

  // Product-stage valid and the merge of both lanes into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_last_q  <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else if (adv) begin
      s1_v_q     <= ctl.issue;
      s1_last_q  <= ctl.last;
      out_v_q    <= s1_v_q;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      left_q  <= left_half;
      right_q <= right_half;
    end
  end

  assign out_valid_o = out_v_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;
  assign last_o      = out_last_q && out_v_q;

  // Never take a frame while a phase step is being issued.
  `SLSR_ASSERT_IMP(a_no_issue_when_ready, in_ready_o, !ctl.issue, "issue while ready")
  // Return to taking frames right after the final step of a frame.
  `SLSR_ASSERT_NEXT(a_ready_after_last, ctl.issue && ctl.last, in_ready_o, "not idle after last")
  // A stalled product stage keeps its item.
  `SLSR_ASSERT_NEXT(a_s1_hold, s1_v_q && !adv, s1_v_q, "product stage item lost")
  // Only an issued step can reach the product stage.
  `SLSR_ASSERT_NEXT(a_s1_source, !ctl.issue && adv, !s1_v_q, "product stage item invented")

endmodule

`default_nettype wire

[bench/stereo_linear_speed_resampler_test.sv]
// Testbench for the stereo linear speed resampler: a directed table, then random frames
// under several speeds and ready/valid idling mixes, scored against an in-bench predictor.
// Depends on slsr_pkg and the stereo_linear_speed_resampler RTL.
`timescale 1ns / 1ps

module stereo_linear_speed_resampler_test;
  import slsr_pkg::*;

  localparam int unsigned SW             = SampleBitsDef;
  localparam int unsigned OneFrame       = 1 << FracBitsDef;
  localparam int unsigned MinSpeed       = OneFrame >> MinSpeedShift;
  localparam int unsigned CycleLimit     = 1000000;
  // Covers the result latency with plenty of margin.
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned ChunkItems     = 48;
  localparam int unsigned ChunkCount     = 8;
  localparam int unsigned MaxPrinted     = 100;

  // One interpolated stereo frame as the block should deliver it.
  typedef struct {
    logic signed [SW-2:0] left;
    logic signed [SW-2:0] right;
    logic                 last;
  } out_frame_t;

  // How a directed row is scored: by the predictor, or by values typed in the table.
  typedef enum int {
    CHECK_PREDICTED,
    CHECK_NONE,
    CHECK_ONE
  } row_check_e;

  typedef struct {
    logic                 cfg_write;
    logic [SpeedBits-1:0] cfg_value;
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    row_check_e           check;
    logic signed [SW-2:0] exp_left;
    logic signed [SW-2:0] exp_right;
  } stim_row_t;

  // Directed table. The first rows run at the reset speed of one frame per output with
  // the phase at zero, so each frame yields exactly the previous frame halved.
  stim_row_t directed_rows [20] = '{
    // first frame after reset: store only
    '{0, 0,      32767, -32768, CHECK_NONE,      0,      0},
    '{0, 0,     -32768,  32767, CHECK_ONE,   16383, -16384},
    '{0, 0,          0,      0, CHECK_ONE,  -16384,  16383},
    '{0, 0,         -1,      1, CHECK_ONE,       0,      0},
    '{0, 0,      32767,  32767, CHECK_ONE,      -1,      0},
    // minimum speed: sixty-four results per frame
    '{1, 64,    -32768, -32768, CHECK_PREDICTED, 0,      0},
    '{0, 0,      32767,      0, CHECK_PREDICTED, 0,      0},
    // speed below the floor, zero and just under: used as the minimum
    '{1, 0,          0,  32767, CHECK_PREDICTED, 0,      0},
    '{0, 0,     -32768,  32767, CHECK_PREDICTED, 0,      0},
    '{1, 63,         1,     -1, CHECK_PREDICTED, 0,      0},
    // one and a half frames per output
    '{1, 6144,   20000, -20000, CHECK_PREDICTED, 0,      0},
    '{0, 0,     -12345,  12345, CHECK_PREDICTED, 0,      0},
    // maximum speed: the phase runs far past one, later frames emit nothing
    '{1, 65535,  32767, -32768, CHECK_PREDICTED, 0,      0},
    '{0, 0,     -32768,  32767, CHECK_PREDICTED, 0,      0},
    '{0, 0,        100,   -100, CHECK_PREDICTED, 0,      0},
    '{0, 0,      21845, -21846, CHECK_PREDICTED, 0,      0},
    '{1, 2731,  -21846,  21845, CHECK_PREDICTED, 0,      0},
    '{0, 0,      32767,  32767, CHECK_PREDICTED, 0,      0},
    '{0, 0,     -32768, -32768, CHECK_PREDICTED, 0,      0},
    '{1, 4096,       7,     -7, CHECK_PREDICTED, 0,      0}
  };

  // Block inputs, all known from time zero.
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [SpeedBits-1:0] cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic signed [SW-1:0] left_sample_i  = '0;
  logic signed [SW-1:0] right_sample_i = '0;
  logic                 out_ready_i    = 1'b0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic signed [SW-2:0] left_out_o;
  logic signed [SW-2:0] right_out_o;
  logic                 last_o;

  // Predictor state: held frame, read phase, priming flag and the speed register copy.
  logic signed [SW-1:0] held_left   = '0;
  logic signed [SW-1:0] held_right  = '0;
  int unsigned          read_phase  = 0;
  logic                 frame_held  = 1'b0;
  logic [SpeedBits-1:0] speed_reg   = SpeedBits'(OneFrame);

  out_frame_t  pending_frames[$];  // expected output frames, oldest first
  out_frame_t  fresh_frames[$];    // frames predicted for the latest input

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_req      = 0;
  int          hold_done     = 0;
  int          error_count   = 0;
  int unsigned cycle_count   = 0;

  stereo_linear_speed_resampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .left_sample_i (left_sample_i),
    .right_sample_i(right_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .last_o        (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MaxPrinted)
      $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
               cycle_count);
    error_count++;
  endtask

  // Interpolate between two samples at the given phase, floor the product, then halve
  // with an arithmetic shift and keep the output width.
  function automatic logic signed [SW-2:0] interp_half(input logic signed [SW-1:0] a,
                                                       input logic signed [SW-1:0] b,
                                                       input int unsigned ph);
    longint diff;
    longint y;
    diff = longint'(b) - longint'(a);
    y = longint'(a) + ((diff * longint'(ph)) >>> FracBitsDef);
    return y[SW-1:1];
  endfunction

  // Advance the predictor by one input frame; leave its results in fresh_frames.
  task automatic resample_frame(input logic signed [SW-1:0] cur_left,
                                input logic signed [SW-1:0] cur_right);
    int unsigned step;
    int          n;
    out_frame_t  f;
    fresh_frames.delete();
    step = (speed_reg < MinSpeed) ? MinSpeed : speed_reg;
    n = 0;
    if (!frame_held) begin
      frame_held = 1'b1;
    end else begin
      while (read_phase < OneFrame && n < MaxResults) begin
        f.left  = interp_half(held_left, cur_left, read_phase);
        f.right = interp_half(held_right, cur_right, read_phase);
        // Last when the next step leaves the frame or the guard count is hit.
        f.last  = (read_phase + step >= OneFrame) || (n + 1 == MaxResults);
        fresh_frames.push_back(f);
        n++;
        read_phase += step;
      end
      if (read_phase >= OneFrame)
        read_phase -= OneFrame;
      else
        read_phase = 0;
    end
    held_left  = cur_left;
    held_right = cur_right;
  endtask

  // Offer one frame, starting at a falling edge, and queue what it should produce once
  // the transaction is taken. Returns at the falling edge after acceptance, valid still
  // high, so back-to-back frames never drop valid within one time step.
  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                            input row_check_e check,
                            input logic signed [SW-2:0] el, input logic signed [SW-2:0] er);
    out_frame_t f;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    resample_frame(l, r);
    if (check == CHECK_PREDICTED) begin
      foreach (fresh_frames[k]) pending_frames.push_back(fresh_frames[k]);
    end else if (check == CHECK_ONE) begin
      f.left  = el;
      f.right = er;
      f.last  = 1'b1;
      pending_frames.push_back(f);
    end
    @(negedge clk_i);
  endtask

  // Hold the input, drain every expected frame, let the pipeline settle, then write the
  // speed register. Frames that cause no result may still be in flight, hence the pause.
  task automatic write_speed(input logic [SpeedBits-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    speed_reg = value;
  endtask

  // Random sample: mostly full range, with extremes and values around zero mixed in.
  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] v;
    case ($urandom_range(9))
      0: v = {1'b0, {(SW-1){1'b1}}};
      1: v = {1'b1, {(SW-1){1'b0}}};
      2: begin
        v = SW'($urandom_range(64));
        v = v - SW'(32);
      end
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  // Speed for each random chunk: reset value, both extremes, zero (raised to the floor), a
  // fully random value, and ranges that give a few results per frame.
  function automatic logic [SpeedBits-1:0] chunk_speed(input int c);
    case (c)
      0: return SpeedBits'(OneFrame);
      1: return SpeedBits'(MinSpeed);
      2: return SpeedBits'($urandom_range(8192, 1024));
      3: return {SpeedBits{1'b1}};
      4: return SpeedBits'($urandom_range(65535));
      5: return SpeedBits'($urandom_range(4096, 256));
      6: return SpeedBits'($urandom_range(16384, 2048));
      default: return '0;
    endcase
  endfunction

  // Receiver: random ready at each falling edge, or a long hold-off when requested so
  // the block fills up and stalls its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_done < hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Scoreboard: compare every output transaction with the oldest expected frame.
  always @(posedge clk_i) begin : score_out
    out_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("output frame with nothing expected, left_out", left_out_o, 0);
      end else begin
        want = pending_frames.pop_front();
        if (left_out_o !== want.left)
          report_mismatch("left_out", left_out_o, want.left);
        if (right_out_o !== want.right)
          report_mismatch("right_out", right_out_o, want.right);
        if (last_o !== want.last)
          report_mismatch("last", last_o, want.last);
      end
    end
  end

  // Stimulus: reset, directed table, random chunks, drain, verdict.
  initial begin
    // Directed rows run with the sender idling lightly and the receiver heavily.
    send_idle_pct = 25;
    recv_idle_pct = 64;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) write_speed(directed_rows[i].cfg_value);
      send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].check,
                 directed_rows[i].exp_left, directed_rows[i].exp_right);
    end

    for (int c = 0; c < ChunkCount; c++) begin
      // Swap the idling mix after the first three chunks, then run the last two with no idling at all.
      if (c < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 64;
      end else if (c < 6) begin
        send_idle_pct = 64;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_speed(chunk_speed(c));
      // Minimum speed chunk: stall the receiver long enough to back up the input.
      if (c == 1) hold_req++;
      for (int k = 0; k < ChunkItems; k++)
        send_frame(pick_sample(), pick_sample(), CHECK_PREDICTED, '0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    // Catch any stray frame that would follow the last expected one.
    repeat (SettleCycles * 2) @(negedge clk_i);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/slsr_pkg.sv
hw/rtl/slsr_lane.sv
hw/rtl/slsr_seq.sv
hw/rtl/stereo_linear_speed_resampler.sv
bench/stereo_linear_speed_resampler_test.sv
